// ----- src/md_pkg.sv -----
package md_pkg;

    // Sequencer states of the modular division block.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_B,
        ST_LOOP,
        ST_DIV_Q,
        ST_MUL_Q,
        ST_CHECK,
        ST_DIV_A,
        ST_MUL_A,
        ST_DONE
    } state_t;

    // Handshake between the sequencer and a shared arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Reset value of the modulus register before truncation to the word width.
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

endpackage

// ----- src/md_divider.sv -----
module md_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_BITS-1:0]  num,
    input  logic [WORD_BITS-1:0]  den,
    output logic [WORD_BITS-1:0]  quo,
    output logic [WORD_BITS-1:0]  rem,
    output md_pkg::unit_status_t  status
);
    import md_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] num_reg, num_next;
    logic [WORD_BITS-1:0] den_reg, den_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   trial;

    // One restoring division step per cycle, most significant bit first.
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[WORD_BITS-1]};
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(WORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[WORD_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = WORD_BITS'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WORD_BITS-1:0];
                quo_next = {quo_reg[WORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quo         = quo_reg;
    assign rem         = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- src/md_mulmod.sv -----
module md_mulmod #(
    parameter int WORD_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_BITS-1:0]  x,
    input  logic [WORD_BITS-1:0]  y,
    input  logic [WORD_BITS-1:0]  m,
    output logic [WORD_BITS-1:0]  prod,
    output md_pkg::unit_status_t  status
);
    import md_pkg::*;

    localparam int CNT_BITS = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] x_reg, x_next;
    logic [WORD_BITS-1:0] y_reg, y_next;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS-1:0] dbl_red;
    logic [WORD_BITS:0]   sum;

    // Double-and-add over the bits of y, both operands below the modulus.
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dbl       = {acc_reg, 1'b0};
        dbl_red   = (dbl >= {1'b0, m_reg}) ? WORD_BITS'(dbl - {1'b0, m_reg})
                                           : dbl[WORD_BITS-1:0];
        sum       = {1'b0, dbl_red} + {1'b0, x_reg};
        if (start)
        begin
            x_next    = x;
            y_next    = y;
            m_next    = m;
            acc_next  = '0;
            cnt_next  = CNT_BITS'(WORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg[WORD_BITS-1])
            begin
                acc_next = (sum >= {1'b0, m_reg}) ? WORD_BITS'(sum - {1'b0, m_reg})
                                                  : sum[WORD_BITS-1:0];
            end
            else
            begin
                acc_next = dbl_red;
            end
            y_next   = {y_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign prod        = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- src/modular_division.sv -----
// Modular division: quotient = dividend * divisor^-1 mod modulus.
// Input stream s_*: one transfer carries dividend and divisor. Output stream
// m_*: one transfer per input carries the quotient in m_tdata and the
// undefined flag in m_tuser; the flag is set, with a zero quotient, when the
// divisor and the modulus are not coprime or the modulus is zero.
// The user writes the modulus through modulus_we / modulus_wdata only while
// idle; the block does not enforce this. An item runs the extended Euclidean
// algorithm on one shared restoring divider and one shared double-and-add
// modular multiplier, waiting for the done flag of each operation. Each
// Euclid step runs one division and one modular multiplication, so the time
// an item takes grows with the number of steps and is far less for small
// operands; for modulus 0 the sequencer goes straight to its final step.
// s_tready is high only while the sequencer is idle, so one item must finish
// before the next is taken; the sequencer returns to idle between them.
// The result sits in an output register; a new item is accepted while it
// waits, and a stalled receiver holds the sequencer at its final step until
// the register frees.
// Reset clears the sequencer and the output valid and loads 1000000007 into
// the modulus register, truncated to WORD_BITS.
module modular_division #(
    parameter int WORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                modulus_we,
    input  logic [WORD_BITS-1:0]                modulus_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*WORD_BITS+7)/8)*8-1:0]    s_tdata,   // dividend, divisor
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((WORD_BITS+7)/8)*8-1:0]      m_tdata,   // quotient
    output logic [0:0]                          m_tuser    // undefined
);
    import md_pkg::*;

    localparam int OUT_BITS = ((WORD_BITS + 7) / 8) * 8;
    localparam logic [WORD_BITS-1:0] MOD_RST = MODULUS_RESET[WORD_BITS-1:0];

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] r0_reg, r0_next;
    logic [WORD_BITS-1:0] r1_reg, r1_next;
    logic [WORD_BITS-1:0] t0_reg, t0_next;
    logic [WORD_BITS-1:0] t1_reg, t1_next;
    logic [WORD_BITS-1:0] q_reg, q_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic                 undef_reg, undef_next;
    logic [WORD_BITS-1:0] out_q_reg, out_q_next;
    logic                 out_u_reg, out_u_next;
    logic                 out_v_reg, out_v_next;

    logic                 div_start, mul_start;
    logic [WORD_BITS-1:0] div_num, div_den, div_quo, div_rem;
    logic [WORD_BITS-1:0] mul_x, mul_y, mul_prod;
    unit_status_t         div_st, mul_st;

    // Modulus register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RST;
        end
        else if (modulus_we)
        begin
            modulus_reg <= modulus_wdata;
        end
    end

    md_divider #(.WORD_BITS(WORD_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .quo    (div_quo),
        .rem    (div_rem),
        .status (div_st)
    );

    md_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .m      (m_reg),
        .prod   (mul_prod),
        .status (mul_st)
    );

    // Sequencer: next state, unit starts and datapath updates.
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        a_next     = a_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        undef_next = undef_reg;
        out_q_next = out_q_reg;
        out_u_next = out_u_reg;
        out_v_next = out_v_reg;
        div_start  = 1'b0;
        div_num    = r0_reg;
        div_den    = r1_reg;
        mul_start  = 1'b0;
        mul_x      = q_reg;
        mul_y      = t1_reg;
        s_tready   = (state_reg == ST_IDLE);

        if (out_v_reg && m_tready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    a_next     = s_tdata[WORD_BITS-1:0];
                    m_next     = modulus_reg;
                    res_next   = '0;
                    undef_next = 1'b1;
                    if (modulus_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = s_tdata[2*WORD_BITS-1:WORD_BITS];
                        div_den    = modulus_reg;
                        state_next = ST_RED_B;
                    end
                end
            end
            ST_RED_B:
            begin
                if (div_st.done)
                begin
                    r0_next    = m_reg;
                    r1_next    = div_rem;
                    t0_next    = '0;
                    t1_next    = (m_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (r1_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_Q;
                end
            end
            ST_DIV_Q:
            begin
                if (div_st.done)
                begin
                    // A quotient equal to the modulus is zero modulo it.
                    q_next     = (div_quo == m_reg) ? '0 : div_quo;
                    r0_next    = r1_reg;
                    r1_next    = div_rem;
                    mul_start  = 1'b1;
                    mul_x      = (div_quo == m_reg) ? '0 : div_quo;
                    state_next = ST_MUL_Q;
                end
            end
            ST_MUL_Q:
            begin
                if (mul_st.done)
                begin
                    t0_next = t1_reg;
                    if (t0_reg >= mul_prod)
                    begin
                        t1_next = t0_reg - mul_prod;
                    end
                    else
                    begin
                        t1_next = t0_reg - mul_prod + m_reg;
                    end
                    state_next = ST_LOOP;
                end
            end
            ST_CHECK:
            begin
                if (r0_reg != WORD_BITS'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = a_reg;
                    div_den    = m_reg;
                    state_next = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (div_st.done)
                begin
                    mul_start  = 1'b1;
                    mul_x      = t0_reg;
                    mul_y      = div_rem;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                if (mul_st.done)
                begin
                    res_next   = mul_prod;
                    undef_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_q_next = res_reg;
                    out_u_next = undef_reg;
                    out_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        a_reg     <= a_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        q_reg     <= q_next;
        res_reg   <= res_next;
        undef_reg <= undef_next;
        out_q_reg <= out_q_next;
        out_u_reg <= out_u_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUT_BITS'(out_q_reg);
    assign m_tuser  = out_u_reg;

endmodule

// ----- bench/modular_division_test.sv -----
`timescale 1ns / 100ps

module modular_division_test;

    import md_pkg::*;

    localparam int WORD_BITS = 32;
    localparam int CYCLE_LIMIT = 30000000;
    localparam int RANDOM_ITEMS = 1450;

    // One expected quotient and its undefined flag.
    typedef struct {
        logic [WORD_BITS-1:0] quotient;
        logic                 undefined;
    } division_result_t;

    // Directed row: operands, and a typed-in result where it is obvious.
    typedef struct {
        logic [WORD_BITS-1:0] dividend;
        logic [WORD_BITS-1:0] divisor;
        logic                 known;
        logic [WORD_BITS-1:0] quotient;
        logic                 undefined;
    } division_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 modulus_we;
    logic [WORD_BITS-1:0] modulus_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;   // dividend, divisor
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // quotient
    logic [0:0]           m_tuser;   // undefined

    logic [WORD_BITS-1:0] modulus_shadow;
    division_result_t     pending_quotients[$];
    int                   error_count;
    int                   result_count;
    int                   undefined_count;
    int                   cycle_count;

    modular_division #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .modulus_we(modulus_we),
        .modulus_wdata(modulus_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Modular product by double-and-add, operands below the modulus.
    function automatic logic [63:0] product_mod(input logic [63:0] x, input logic [63:0] y,
                                                input logic [63:0] m);
        logic [64:0] acc;
        acc = '0;
        for (int i = 63; i >= 0; i--)
        begin
            acc = acc + acc;
            if (acc >= {1'b0, m})
                acc = acc - {1'b0, m};
            if (y[i])
            begin
                acc = acc + {1'b0, x};
                if (acc >= {1'b0, m})
                    acc = acc - {1'b0, m};
            end
        end
        return acc[63:0];
    endfunction

    // Predicts the division result under the current modulus.
    function automatic division_result_t predict_quotient(input logic [WORD_BITS-1:0] dividend,
                                                          input logic [WORD_BITS-1:0] divisor);
        division_result_t res;
        logic [63:0] m, r0, r1, r2, t0, t1, t2, q, p;
        m = 64'(modulus_shadow);
        res.quotient = '0;
        res.undefined = 1'b1;
        if (m == 64'd0)
            return res;
        r0 = m;
        r1 = 64'(divisor) % m;
        t0 = 64'd0;
        t1 = (m == 64'd1) ? 64'd0 : 64'd1;
        for (int k = 0; k < 2 * WORD_BITS + 4 && r1 != 64'd0; k++)
        begin
            q = r0 / r1;
            r2 = r0 - q * r1;
            p = product_mod(q % m, t1, m);
            t2 = (t0 >= p) ? t0 - p : t0 + (m - p);
            r0 = r1;
            r1 = r2;
            t0 = t1;
            t1 = t2;
        end
        if (r0 != 64'd1)
            return res;
        p = product_mod(t0, 64'(dividend) % m, m);
        res.quotient = p[WORD_BITS-1:0];
        res.undefined = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Sends one item after a random gap and records its expectation.
    // The valid stays high after a transfer until the next call or a register write.
    task automatic send_division(input division_row_t row);
        int gap;
        division_result_t res;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        res = predict_quotient(row.dividend, row.divisor);
        if (row.known)
        begin
            if (res.quotient !== row.quotient || res.undefined !== row.undefined)
                report_mismatch("typed-in row", 64'({res.undefined, res.quotient}),
                                64'({row.undefined, row.quotient}));
            res.quotient = row.quotient;
            res.undefined = row.undefined;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row.divisor, row.dividend};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_quotients.insert(pending_quotients.size(), res);
        @(negedge clk);
    endtask

    // Waits until all results are in, plus a margin, before a register write.
    task automatic write_modulus(input logic [WORD_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_quotients.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        modulus_we <= 1'b1;
        modulus_wdata <= value;
        @(negedge clk);
        modulus_we <= 1'b0;
        modulus_shadow = value;
    endtask

    function automatic division_row_t make_row(input logic [WORD_BITS-1:0] a,
                                               input logic [WORD_BITS-1:0] b);
        division_row_t row;
        row.dividend = a;
        row.divisor = b;
        row.known = 1'b0;
        row.quotient = '0;
        row.undefined = 1'b0;
        return row;
    endfunction

    function automatic division_row_t make_known(input logic [WORD_BITS-1:0] a,
                                                 input logic [WORD_BITS-1:0] b,
                                                 input logic [WORD_BITS-1:0] q,
                                                 input logic u);
        division_row_t row;
        row = make_row(a, b);
        row.known = 1'b1;
        row.quotient = q;
        row.undefined = u;
        return row;
    endfunction

    // Half the operands are small, to keep the Euclid loop short; the other half are full width.
    function automatic logic [WORD_BITS-1:0] random_operand();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 255);
            1: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, checks each transfer against the oldest expectation.
    initial
    begin
        division_result_t want;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (pending_quotients.size() == 0)
            begin
                report_mismatch("unexpected transfer", 64'(m_tdata), 64'd0);
            end
            else
            begin
                want = pending_quotients.pop_front();
                result_count++;
                if (m_tuser[0])
                    undefined_count++;
                if (m_tdata !== want.quotient)
                    report_mismatch("quotient", 64'(m_tdata), 64'(want.quotient));
                if (m_tuser[0] !== want.undefined)
                    report_mismatch("undefined flag", 64'(m_tuser), 64'(want.undefined));
            end
        end
    end

    // Cycle counter; stops the run with an error at the cycle limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("run stopped at the cycle limit");
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus: directed items for a few moduli, then random items over several moduli.
    initial
    begin
        division_row_t directed[$];
        logic [WORD_BITS-1:0] moduli[$];
        logic [WORD_BITS-1:0] m, a, b;
        int kind;
        rst_n = 1'b0;
        modulus_we = 1'b0;
        modulus_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        error_count = 0;
        result_count = 0;
        undefined_count = 0;
        modulus_shadow = MODULUS_RESET[WORD_BITS-1:0];
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset the modulus is 1000000007.
        directed = {make_known(32'd6, 32'd3, 32'd2, 1'b0),
                    make_known(32'd5, 32'd1, 32'd5, 1'b0),
                    make_known(32'd5, 32'd0, 32'd0, 1'b1),
                    make_known(32'd9, 32'd1000000007, 32'd0, 1'b1),
                    make_known(32'd1, 32'd2000000014, 32'd0, 1'b1),
                    make_known(32'd1000000008, 32'd1, 32'd1, 1'b0),
                    make_row(32'hFFFF_FFFF, 32'hFFFF_FFFF),
                    make_row(32'h0, 32'hFFFF_FFFF),
                    make_row(32'hAAAA_AAAA, 32'h5555_5555),
                    make_row(32'h5555_5555, 32'hAAAA_AAAA),
                    make_row(32'd1, 32'd2)};
        foreach (directed[i])
            send_division(directed[i]);

        // Modulus one: everything is zero and defined.
        write_modulus(32'd1);
        send_division(make_known(32'd0, 32'd0, 32'd0, 1'b0));
        send_division(make_known(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0));
        // Modulus zero: always undefined.
        write_modulus(32'd0);
        send_division(make_known(32'd7, 32'd3, 32'd0, 1'b1));
        send_division(make_known(32'hFFFF_FFFF, 32'd1, 32'd0, 1'b1));
        // Largest modulus.
        write_modulus(32'hFFFF_FFFF);
        send_division(make_known(32'd4, 32'hFFFF_FFFF, 32'd0, 1'b1));
        send_division(make_known(32'd4, 32'd3, 32'd0, 1'b1));
        send_division(make_row(32'hFFFF_FFFE, 32'd2));
        send_division(make_row(32'hFFFF_FFFE, 32'hFFFF_FFFE));
        // Composite modulus with a shared factor.
        write_modulus(32'd12);
        send_division(make_known(32'd5, 32'd6, 32'd0, 1'b1));
        send_division(make_known(32'd7, 32'd5, 32'd11, 1'b0));

        moduli = '{32'd1000000007, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'd0,
                   32'd97, 32'd360, 32'hFFFF_FFFB, 32'd65536};
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < moduli.size())
                m = moduli[phase];
            else
                m = $urandom;
            write_modulus(m);
            for (int n = 0; n < RANDOM_ITEMS / 12; n++)
            begin
                a = random_operand();
                kind = $urandom_range(0, 9);
                if (kind == 0 && m != 0)
                    b = m * $urandom_range(0, 3);
                else if (kind == 1)
                    b = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                else
                    b = random_operand();
                send_division(make_row(a, b));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_quotients.size() != 0)
            @(negedge clk);
        repeat (4000) @(negedge clk);
        $display("checked %0d quotients, %0d flagged undefined, across %0d modulus settings",
                 result_count, undefined_count, 17);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/md_pkg.sv
src/md_divider.sv
src/md_mulmod.sv
src/modular_division.sv
bench/modular_division_test.sv
